// ===== hdl/qdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qdrs_pkg
// Shared types, constants and the quadrature step table for the detent
// report stretcher.
// ----------------------------------------------------------------------------
package qdrs_pkg;

    // report layout
    localparam int SHIFT_BITS   = 16;
    localparam int DIRECT_BITS  = 5;
    localparam int DETENT_BITS  = 10;
    localparam int REPORT_BITS  = SHIFT_BITS + DIRECT_BITS + DETENT_BITS;
    localparam int MAX_ENCODERS = 5;

    // field widths
    localparam int IDX_W   = 3;
    localparam int PHASE_W = 2;
    localparam int THR_W   = 4;
    localparam int TOTAL_W = 6;
    localparam int BYTE_W  = 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [THR_W-1:0]      THRESHOLD_RESET = 4'd3;

    // item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // one encoder sample handed to the detent tracker
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   index;
        logic [PHASE_W-1:0] phases;
    } t_enc_sample;

    typedef logic signed [1:0] t_step;

    // signed step from {old phases, new phases}
    function automatic t_step step_of(input logic [3:0] code);
        t_step s;
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default:                 s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/quadrature_detent_report_stretcher.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_report_stretcher
// Quadrature detent decoder for up to five encoders plus button change
// report with a per-bit stretch window of WINDOW_DEPTH ticks.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------
//  input     in         i_valid / o_stall     i_mode, i_encoder_index, ...
//  result    out        o_valid / i_stall     o_report (one per report tick)
//  config    in         psel/penable/pready   detent_threshold at byte 0
//
//  An item is captured in the input register, and a tick's result then enters
//  the output register. One item per cycle is taken while no tick is stalled.
//  Encoder samples finish in the input register and never wait on i_stall.
//  A tick waits in the input register only while the output register holds
//  a result that is stalled. Synchronous active-low reset; no clearing pass.
//
module quadrature_detent_report_stretcher import qdrs_pkg::*; #(
    parameter int WINDOW_DEPTH  = 128,
    parameter int ENCODER_COUNT = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_mode,
    input  logic [IDX_W-1:0]       i_encoder_index,
    input  logic [PHASE_W-1:0]     i_encoder_phases,
    input  logic [BYTE_W-1:0]      i_shift_buttons_low,
    input  logic [BYTE_W-1:0]      i_shift_buttons_high,
    input  logic [DIRECT_BITS-1:0] i_direct_buttons_raw,
    // result items
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [REPORT_BITS-1:0] o_report,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // input register
    logic                   r_in_v;
    logic                   r_mode;
    logic [IDX_W-1:0]       r_idx;
    logic [PHASE_W-1:0]     r_phases;
    logic [SHIFT_BITS-1:0]  r_shift;
    logic [DIRECT_BITS-1:0] r_direct;

    // block state and output register
    logic [THR_W-1:0]       r_threshold;
    logic [SHIFT_BITS-1:0]  r_last_shift;
    logic                   r_out_v;
    logic [REPORT_BITS-1:0] r_report;

    logic                   in_acc;
    logic                   is_tick;
    logic                   out_free;
    logic                   advance;
    logic                   tick_go;
    t_enc_sample            sample;
    logic [DETENT_BITS-1:0] pending;
    logic [REPORT_BITS-1:0] mask;
    logic [REPORT_BITS-1:0] report;

    // handshake
    assign in_acc   = i_valid && !o_stall;
    assign is_tick  = r_mode == MODE_TICK;
    assign out_free = !r_out_v || !i_stall;
    assign advance  = r_in_v && (!is_tick || out_free);
    assign tick_go  = advance && is_tick;
    assign o_stall  = r_in_v && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_acc) begin
            r_in_v <= 1'b1;
        end else if (advance) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= i_mode;
            r_idx    <= i_encoder_index;
            r_phases <= i_encoder_phases;
            r_shift  <= {i_shift_buttons_high, i_shift_buttons_low};
            r_direct <= i_direct_buttons_raw;
        end
    end

    // detent tracking
    assign sample.valid  = advance && (r_mode == MODE_SAMPLE);
    assign sample.index  = r_idx;
    assign sample.phases = r_phases;

    qdrs_detent #(
        .ENCODER_COUNT(ENCODER_COUNT)
    ) u_detent (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample),
        .i_tick     (tick_go),
        .i_threshold(r_threshold),
        .o_pending  (pending)
    );

    // change mask: toggled shift buttons, pressed direct buttons, detents
    assign mask = {pending, ~r_direct, r_shift ^ r_last_shift};

    qdrs_stretch #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_stretch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_go),
        .i_mask  (mask),
        .o_report(report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_shift <= '0;
        end else if (tick_go) begin
            r_last_shift <= r_shift;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (tick_go) begin
            r_out_v <= 1'b1;
        end else if (out_free) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_report <= report;
        end
    end

    assign o_valid  = r_out_v;
    assign o_report = r_report;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESHOLD)
                  ? {{(APB_DATA_W-THR_W){1'b0}}, r_threshold} : '0;

endmodule

// ===== hdl/qdrs_detent.sv =====
// ----------------------------------------------------------------------------
// qdrs_detent
// Per-encoder phase history and step totals; flags left and right detents
// until the next report tick collects them.
// ----------------------------------------------------------------------------
module qdrs_detent import qdrs_pkg::*; #(
    parameter int ENCODER_COUNT = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_enc_sample            i_sample,
    input  logic                   i_tick,
    input  logic [THR_W-1:0]       i_threshold,
    output logic [DETENT_BITS-1:0] o_pending
);

    logic signed [TOTAL_W:0] thr_pos;
    logic signed [TOTAL_W:0] thr_neg;

    assign thr_pos = $signed({{(TOTAL_W+1-THR_W){1'b0}}, i_threshold});
    assign thr_neg = -thr_pos;

    // one lane per encoder
    for (genvar e = 0; e < MAX_ENCODERS; e++) begin : g_lane
        if (e < ENCODER_COUNT) begin : g_used
            logic [PHASE_W-1:0]        r_hist;
            logic signed [TOTAL_W-1:0] r_total;
            logic [1:0]                r_pend;
            logic                      sel;
            t_step                     step;
            logic signed [TOTAL_W:0]   sum;
            logic                      left;
            logic                      right;

            assign sel   = i_sample.valid && (i_sample.index == IDX_W'(e));
            assign step  = step_of({r_hist, i_sample.phases});
            assign sum   = $signed({r_total[TOTAL_W-1], r_total})
                         + $signed({{(TOTAL_W-1){step[1]}}, step});
            assign left  = sum > thr_pos;
            assign right = sum < thr_neg;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_hist  <= '0;
                    r_total <= '0;
                    r_pend  <= '0;
                end else if (i_tick) begin
                    r_pend <= '0;
                end else if (sel) begin
                    r_hist  <= i_sample.phases;
                    r_total <= (left || right) ? '0 : sum[TOTAL_W-1:0];
                    r_pend  <= r_pend | {right, left};
                end
            end

            assign o_pending[2*e +: 2] = r_pend;
        end else begin : g_unused
            assign o_pending[2*e +: 2] = 2'b00;
        end
    end

endmodule

// ===== hdl/qdrs_stretch.sv =====
// ----------------------------------------------------------------------------
// qdrs_stretch
// Saturating age counter per report bit; a bit reads high while its last
// change is fewer than WINDOW_DEPTH ticks old.
// ----------------------------------------------------------------------------
module qdrs_stretch import qdrs_pkg::*; #(
    parameter int WINDOW_DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_tick,
    input  logic [REPORT_BITS-1:0] i_mask,
    output logic [REPORT_BITS-1:0] o_report
);

    localparam int AGE_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WINDOW_DEPTH);

    for (genvar b = 0; b < REPORT_BITS; b++) begin : g_bit
        logic [AGE_W-1:0] r_age;
        logic [AGE_W-1:0] n_age;

        // clear on change, else count up to saturation
        always_comb begin
            if (i_mask[b]) begin
                n_age = '0;
            end else if (r_age < AGE_MAX) begin
                n_age = r_age + AGE_W'(1);
            end else begin
                n_age = r_age;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_age <= AGE_MAX;
            end else if (i_tick) begin
                r_age <= n_age;
            end
        end

        assign o_report[b] = n_age < AGE_MAX;
    end

endmodule

// ===== bench/tb_quadrature_detent_report_stretcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_detent_report_stretcher
// Self-checking bench for the quadrature detent report stretcher. A short
// table of directed items is followed by random encoder rotations, noise
// samples and report ticks under several detent thresholds. Every accepted
// item runs through a local detent and stretch tracker, and each report
// that comes out is compared with the oldest predicted report.
// ----------------------------------------------------------------------------
module tb_quadrature_detent_report_stretcher import qdrs_pkg::*; ();

    localparam int WINDOW_DEPTH  = 128;
    localparam int ENCODER_COUNT = 5;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int MAX_WAIT      = 14;
    localparam int QUIET_TICKS   = WINDOW_DEPTH + 4;
    localparam int SIDE_TX       = 0;
    localparam int SIDE_RX       = 1;

    // step direction per {old phases, new phases}
    localparam logic [15:0] STEP_UP   = 16'h2814;
    localparam logic [15:0] STEP_DOWN = 16'h4182;
    // next phases of a clean rotation, two bits per current phase value
    localparam logic [7:0]  NEXT_UP   = 8'h72;
    localparam logic [7:0]  NEXT_DOWN = 8'h8d;

    typedef struct packed {
        logic                   mode;
        logic [IDX_W-1:0]       index;
        logic [PHASE_W-1:0]     phases;
        logic [BYTE_W-1:0]      btn_low;
        logic [BYTE_W-1:0]      btn_high;
        logic [DIRECT_BITS-1:0] direct_raw;
    } t_item;

    typedef struct packed {
        t_item                  item;
        logic                   known;
        logic [REPORT_BITS-1:0] report;
    } t_vector;

    // clock, reset and block ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic                   i_mode = 1'b0;
    logic [IDX_W-1:0]       i_encoder_index = '0;
    logic [PHASE_W-1:0]     i_encoder_phases = '0;
    logic [BYTE_W-1:0]      i_shift_buttons_low = '0;
    logic [BYTE_W-1:0]      i_shift_buttons_high = '0;
    logic [DIRECT_BITS-1:0] i_direct_buttons_raw = '1;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [REPORT_BITS-1:0] o_report;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // tracker state
    logic [THR_W-1:0]       thr_q = THRESHOLD_RESET;
    logic [PHASE_W-1:0]     enc_phase [MAX_ENCODERS] = '{default: '0};
    int                     step_sum [MAX_ENCODERS] = '{default: 0};
    logic [DETENT_BITS-1:0] detents_noted = '0;
    logic [SHIFT_BITS-1:0]  shift_seen = '0;
    int                     bit_age [REPORT_BITS] = '{default: WINDOW_DEPTH};

    logic [REPORT_BITS-1:0] pending_reports [$];
    int                     fail_count = 0;
    int                     calm_left [2] = '{default: 0};
    int                     idle_cycles = 0;

    quadrature_detent_report_stretcher #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ENCODER_COUNT(ENCODER_COUNT)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_encoder_index     (i_encoder_index),
        .i_encoder_phases    (i_encoder_phases),
        .i_shift_buttons_low (i_shift_buttons_low),
        .i_shift_buttons_high(i_shift_buttons_high),
        .i_direct_buttons_raw(i_direct_buttons_raw),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_report            (o_report),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // wait before the next item or result: mostly a random draw up to MAX_WAIT, with calm runs of no waiting
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left[side] = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_item make_sample(input logic [IDX_W-1:0] index,
                                          input logic [PHASE_W-1:0] phases);
        t_item it;
        it = '0;
        it.mode = MODE_SAMPLE;
        it.index = index;
        it.phases = phases;
        it.direct_raw = '1;
        return it;
    endfunction

    function automatic t_item make_tick(input logic [SHIFT_BITS-1:0] buttons,
                                        input logic [DIRECT_BITS-1:0] raw);
        t_item it;
        it = '0;
        it.mode = MODE_TICK;
        it.btn_low = buttons[7:0];
        it.btn_high = buttons[15:8];
        it.direct_raw = raw;
        return it;
    endfunction

    function automatic t_vector row(input t_item it, input logic known,
                                    input logic [REPORT_BITS-1:0] rep);
        t_vector v;
        v.item = it;
        v.known = known;
        v.report = rep;
        return v;
    endfunction

    // encoder sample: accumulate the step and note a detent past the threshold
    function automatic void track_sample(input logic [IDX_W-1:0] index,
                                         input logic [PHASE_W-1:0] phases);
        logic [3:0] code;
        int         sum;
        if (index >= ENCODER_COUNT)
            return;
        code = {enc_phase[index], phases};
        enc_phase[index] = phases;
        sum = step_sum[index];
        if (STEP_UP[code])
            sum++;
        else if (STEP_DOWN[code])
            sum--;
        if (sum > int'(thr_q)) begin
            sum = 0;
            detents_noted[2*index] = 1'b1;
        end else if (sum < -int'(thr_q)) begin
            sum = 0;
            detents_noted[2*index+1] = 1'b1;
        end
        step_sum[index] = sum;
    endfunction

    // report tick: build the change mask and age every report bit
    function automatic logic [REPORT_BITS-1:0] stretch_tick(input t_item it);
        logic [SHIFT_BITS-1:0]  now;
        logic [REPORT_BITS-1:0] changed;
        logic [REPORT_BITS-1:0] held;
        now = {it.btn_high, it.btn_low};
        changed = {detents_noted, ~it.direct_raw, now ^ shift_seen};
        shift_seen = now;
        detents_noted = '0;
        held = '0;
        for (int b = 0; b < REPORT_BITS; b++) begin
            if (changed[b])
                bit_age[b] = 0;
            else if (bit_age[b] < WINDOW_DEPTH)
                bit_age[b]++;
            held[b] = (bit_age[b] < WINDOW_DEPTH);
        end
        return held;
    endfunction

    // drive one item, hold it until accepted, then update the tracker
    task automatic send_item(input t_vector v);
        int                     gap;
        logic [REPORT_BITS-1:0] predicted;
        gap = draw_wait(SIDE_TX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_mode               <= v.item.mode;
        i_encoder_index      <= v.item.index;
        i_encoder_phases     <= v.item.phases;
        i_shift_buttons_low  <= v.item.btn_low;
        i_shift_buttons_high <= v.item.btn_high;
        i_direct_buttons_raw <= v.item.direct_raw;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (v.item.mode == MODE_TICK) begin
            predicted = stretch_tick(v.item);
            pending_reports.push_back(v.known ? v.report : predicted);
        end else begin
            track_sample(v.item.index, v.item.phases);
        end
    endtask

    task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_THRESHOLD;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_threshold();
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== {{(APB_DATA_W-THR_W){1'b0}}, thr_q}) begin
            $error("detent_threshold: expected %0d, got %0d", thr_q, rdata);
            fail_count++;
        end
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        logic [APB_DATA_W-1:0] ignored;
        apb_access(1'b1, {{(APB_DATA_W-THR_W){1'b0}}, value}, ignored);
        thr_q = value;
        check_threshold();
    endtask

    // wait until every report is back and any sample has left the pipe
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly clean rotations and ticks, some broken rotations and noise
    task automatic random_phase(input int n_items);
        int                     sent;
        int                     pick;
        int                     len;
        logic [IDX_W-1:0]       e;
        logic                   up;
        logic [PHASE_W-1:0]     ph;
        logic [SHIFT_BITS-1:0]  buttons;
        logic [DIRECT_BITS-1:0] raw;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                e = IDX_W'($urandom_range(0, ENCODER_COUNT-1));
                up = 1'($urandom_range(0, 1));
                len = $urandom_range(1, 2*thr_q + 3);
                repeat (len) begin
                    if ($urandom_range(0, 7) == 0)
                        ph = PHASE_W'($urandom_range(0, 3));
                    else if (up)
                        ph = NEXT_UP[2*enc_phase[e] +: 2];
                    else
                        ph = NEXT_DOWN[2*enc_phase[e] +: 2];
                    send_item(row(make_sample(e, ph), 1'b0, '0));
                    sent++;
                end
            end else if (pick < 7) begin
                // few button changes
                buttons = shift_seen;
                if ($urandom_range(0, 1))
                    buttons = buttons ^ (16'h1 << $urandom_range(0, 15));
                raw = '1;
                if ($urandom_range(0, 2) == 0)
                    raw = raw & ~(5'h1 << $urandom_range(0, 4));
                send_item(row(make_tick(buttons, raw), 1'b0, '0));
                sent++;
            end else if (pick == 7) begin
                // noise, including indexes past the last encoder
                e = IDX_W'($urandom_range(0, 7));
                send_item(row(make_sample(e, PHASE_W'($urandom_range(0, 3))), 1'b0, '0));
                if (e < ENCODER_COUNT)
                    sent++;
            end else if (pick == 8) begin
                send_item(row(make_tick(SHIFT_BITS'($urandom_range(0, 16'hffff)),
                                        DIRECT_BITS'($urandom_range(0, 31))),
                              1'b0, '0));
                sent++;
            end else begin
                send_item(row(make_tick(shift_seen, '1), 1'b0, '0));
                sent++;
            end
        end
    endtask

    // result side: random stalls, compare against the oldest prediction
    initial begin : report_checker
        int                     wait_cycles;
        logic [REPORT_BITS-1:0] want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            wait_cycles = draw_wait(SIDE_RX);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (pending_reports.size() == 0) begin
                $error("report: unexpected result %h", o_report);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_report !== want) begin
                    $error("report: expected %h, got %h", want, o_report);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main_sequence
        t_vector directed [$];

        // after reset nothing has changed; then every button changes at once
        directed.push_back(row(make_tick(16'h0000, 5'h1f), 1'b1, 31'h0000_0000));
        directed.push_back(row(make_tick(16'hffff, 5'h00), 1'b1, 31'h001f_ffff));
        // encoder 0 turns four steps down: right detent past -3
        directed.push_back(row(make_sample(3'd0, 2'd1), 1'b0, '0));
        directed.push_back(row(make_sample(3'd0, 2'd3), 1'b0, '0));
        directed.push_back(row(make_sample(3'd0, 2'd2), 1'b0, '0));
        directed.push_back(row(make_sample(3'd0, 2'd0), 1'b0, '0));
        // encoder 4 turns eight steps up: two left detents, one pending bit
        directed.push_back(row(make_sample(3'd4, 2'd2), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd3), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd1), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd0), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd2), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd3), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd1), 1'b0, '0));
        directed.push_back(row(make_sample(3'd4, 2'd0), 1'b0, '0));
        // indexes past the last encoder are dropped
        directed.push_back(row(make_sample(3'd5, 2'd3), 1'b0, '0));
        directed.push_back(row(make_sample(3'd7, 2'd1), 1'b0, '0));
        // phase jump over two states gives no step
        directed.push_back(row(make_sample(3'd2, 2'd3), 1'b0, '0));
        directed.push_back(row(make_tick(16'hffff, 5'h1f), 1'b0, '0));
        directed.push_back(row(make_tick(16'hff00, 5'h15), 1'b0, '0));
        directed.push_back(row(make_tick(16'h55aa, 5'h1f), 1'b0, '0));
        directed.push_back(row(make_tick(16'h55aa, 5'h0e), 1'b0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_threshold();

        foreach (directed[k])
            send_item(directed[k]);
        random_phase(70);
        settle();

        set_threshold(4'd15);
        random_phase(60);
        settle();

        set_threshold(4'd1);
        random_phase(60);
        settle();

        // zero threshold: every real step is a detent
        set_threshold(4'd0);
        random_phase(40);
        settle();

        // long run without changes so every stretched bit expires
        set_threshold(THR_W'($urandom_range(2, 14)));
        repeat (QUIET_TICKS)
            send_item(row(make_tick(shift_seen, '1), 1'b0, '0));
        random_phase(50);
        settle();

        repeat (4 * DRAIN_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("report: %0d results never arrived", pending_reports.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
